/* rtl/core/header_sync_checksum_frame_receiver_top_assert.svh */
// assertion macros shared by the frame receiver rtl
// no dependencies; included by the modules that carry checks
`ifndef HEADER_SYNC_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH
`define HEADER_SYNC_CHECKSUM_FRAME_RECEIVER_TOP_ASSERT_SVH

// check a property every clock edge, suspended while reset is high
`define HSCFR_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// check a property every clock edge, reset included
`define HSCFR_ASSERT_ALWAYS(lbl, clk_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) (prop)) else $error(msg);

`endif

/* rtl/core/hscfr_pkg.sv */
// shared types and constants for the header-synchronised frame receiver
// no dependencies
package hscfr_pkg;

  localparam int FRAME_LEN_DEF = 8;

  // frame byte positions used to build a result
  localparam int TARGET_IDX = 1;
  localparam int ACTION_IDX = 2;
  localparam int ARG1_HI_IDX = 3;
  localparam int ARG1_LO_IDX = 4;
  localparam int ARG2_HI_IDX = 5;
  localparam int ARG2_LO_IDX = 6;
  localparam int TAG_IDX = 7;

  localparam logic [7:0] ACK_FIRST = 8'hCC;
  localparam logic [7:0] ACK_SECOND = 8'hF2;

  typedef struct packed {
    logic [7:0]  target_code;
    logic [7:0]  action_code;
    logic [15:0] first_arg;
    logic [15:0] second_arg;
    logic [7:0]  ack_tag;
    logic [7:0]  ack_check;
  } frame_result_t;

endpackage

/* rtl/core/hscfr_in_stage.sv */
// input register for received bytes, stalls when full and not draining
// depends on hscfr_pkg (import only)
module hscfr_in_stage (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       advance,
  output logic       stage_valid,
  output logic [7:0] stage_byte
);
  import hscfr_pkg::*;

  assign in_stall = stage_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!in_stall) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      stage_byte <= rx_byte;
    end
  end

endmodule

/* rtl/core/hscfr_deframer.sv */
// header hunt, byte capture and checksum compare for one byte a cycle while fire is high
// depends on hscfr_pkg and the assertion macro header
module hscfr_deframer #(
  parameter int FRAME_LEN = hscfr_pkg::FRAME_LEN_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [7:0]                cfg_data,
  input  logic                      fire,
  input  logic [7:0]                in_byte,
  output logic                      res_valid,
  output hscfr_pkg::frame_result_t  res
);
  import hscfr_pkg::*;

  `include "header_sync_checksum_frame_receiver_top_assert.svh"

  localparam int PW = $clog2(FRAME_LEN);
  localparam logic [PW-1:0] LAST_POS = PW'(FRAME_LEN - 1);
  localparam logic [PW-1:0] HUNT_POS = '0;

  logic [7:0]    header;
  logic [PW-1:0] pos;
  logic [PW-1:0] pos_next;
  logic [7:0]    sum;
  logic [7:0]    sum_next;
  logic [7:0]    store [1:TAG_IDX];
  logic [7:0]    cur [1:TAG_IDX];

  always_comb begin
    pos_next = pos;
    sum_next = sum;
    res_valid = 1'b0;
    if (fire) begin
      priority if (pos == HUNT_POS) begin
        if (in_byte == header) begin
          pos_next = PW'(1);
        end
        sum_next = in_byte;
      end else if (pos == LAST_POS) begin
        pos_next = HUNT_POS;
        res_valid = (sum == in_byte);
      end else begin
        pos_next = pos + PW'(1);
        sum_next = sum + in_byte;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      header <= '0;
      pos <= HUNT_POS;
      sum <= '0;
    end else begin
      if (cfg_we) begin
        header <= cfg_data;
      end
      pos <= pos_next;
      sum <= sum_next;
    end
  end

  // one byte register per frame position that a result reads
  for (genvar k = 1; k <= TAG_IDX; k++) begin : g_store
    always_ff @(posedge clk) begin
      if (fire && pos == PW'(k)) begin
        store[k] <= in_byte;
      end
    end
    // the byte arriving now is not yet in the store
    assign cur[k] = (pos == PW'(k)) ? in_byte : store[k];
  end

  always_comb begin
    res.target_code = cur[TARGET_IDX];
    res.action_code = cur[ACTION_IDX];
    res.first_arg = {cur[ARG1_HI_IDX], cur[ARG1_LO_IDX]};
    res.second_arg = {cur[ARG2_HI_IDX], cur[ARG2_LO_IDX]};
    res.ack_tag = cur[TAG_IDX];
    res.ack_check = cur[TAG_IDX] + ACK_FIRST + ACK_SECOND;
  end

  `HSCFR_ASSERT(a_frame_end_hunts, clk, rst, (fire && pos == LAST_POS) |=> (pos == HUNT_POS), "position did not return to hunting after the last byte")
  `HSCFR_ASSERT(a_hunt_drops, clk, rst, (fire && pos == HUNT_POS && in_byte != header) |=> (pos == HUNT_POS), "left hunting on a non-header byte")
  `HSCFR_ASSERT(a_result_at_end, clk, rst, res_valid |-> (fire && pos == LAST_POS), "result raised away from the last frame byte")

endmodule

/* rtl/core/hscfr_out_stage.sv */
// result register; loads whenever empty or being taken downstream
// depends on hscfr_pkg
module hscfr_out_stage (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      fire,
  input  logic                      res_valid,
  input  hscfr_pkg::frame_result_t  res,
  output logic                      advance,
  output logic                      out_valid,
  input  logic                      out_stall,
  output hscfr_pkg::frame_result_t  out_res
);
  import hscfr_pkg::*;

  assign advance = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res_valid) begin
      out_res <= res;
    end
  end

endmodule

/* rtl/core/header_sync_checksum_frame_receiver_top.sv */
// channel   | direction | handshake            | payload
// ----------+-----------+----------------------+-------------------------------------
// rx bytes  | in        | in_valid / in_stall  | rx_byte
// results   | out       | out_valid / out_stall| target_code .. ack_check
// header    | in        | cfg_valid / cfg_ready| cfg_data
//
// one byte is taken every cycle while in_stall is low; a result passes from its last byte
// through the input register, then one pass of hunt/sum logic into the result register
// reset is synchronous: hunting, zero header, both stages empty; frame bytes keep old values
// a stalled result backs up into the input register, then in_stall rises in the same cycle
// the header register is always ready and takes effect from the next hunt
module header_sync_checksum_frame_receiver_top #(
  parameter int FRAME_LEN = hscfr_pkg::FRAME_LEN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  target_code,
  output logic [7:0]  action_code,
  output logic [15:0] first_arg,
  output logic [15:0] second_arg,
  output logic [7:0]  ack_tag,
  output logic [7:0]  ack_check
);
  import hscfr_pkg::*;

  `include "header_sync_checksum_frame_receiver_top_assert.svh"

  logic          advance;
  logic          stage_valid;
  logic [7:0]    stage_byte;
  logic          fire;
  logic          res_valid;
  frame_result_t res;
  frame_result_t out_res;

  assign cfg_ready = 1'b1;
  assign fire = stage_valid && advance;

  hscfr_in_stage u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .advance     (advance),
    .stage_valid (stage_valid),
    .stage_byte  (stage_byte)
  );

  hscfr_deframer #(
    .FRAME_LEN (FRAME_LEN)
  ) u_deframer (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .in_byte   (stage_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  hscfr_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign target_code = out_res.target_code;
  assign action_code = out_res.action_code;
  assign first_arg = out_res.first_arg;
  assign second_arg = out_res.second_arg;
  assign ack_tag = out_res.ack_tag;
  assign ack_check = out_res.ack_check;

  `HSCFR_ASSERT(a_stall_when_full, clk, rst, in_stall |-> (stage_valid && out_valid && out_stall), "input stalled without a blocked result")
  `HSCFR_ASSERT(a_new_result_from_byte, clk, rst, (out_valid && !$past(out_valid)) |-> $past(fire), "result appeared without a processed byte")
  `HSCFR_ASSERT_ALWAYS(a_reset_empties, clk, $past(rst) |-> (!out_valid && !stage_valid), "stages not empty after reset")

endmodule
